>>> rtl/rwmj_pkg.sv
// rwmj_pkg: shared constants, controller states and divider status type
// for the rtt window mean / jitter unit; no dependencies
package rwmj_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_W     = 16;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int FRAC_W       = 8;
    localparam int DVD_W        = SUM_W + FRAC_W;
    localparam int RESULT_W     = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_RD_NEXT,
        ST_EVICT,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE
    } rwmj_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/rtt_window_mean_jitter_unit.sv
// rtt_window_mean_jitter_unit: sliding window mean and jitter of rtt samples
// depends on rwmj_pkg, rwmj_ring_mem, rwmj_serial_div
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_rtt_sample[15:0]
//  m_      | out       | m_valid / m_ready  | m_mean_rtt, m_jitter, m_last_rtt, m_sample_count
//
// from transfer to result an item passes an update step, then the bit-serial
// divisions of DVD_W = 28 steps, mean and jitter side by side, and waits for a
// free output; once the window is full, two ring reads and an eviction step come first
// synchronous active-low reset clears state, count, sums, slot and output valid; the ring needs no clear
// a waiting result sits in the output register while the next sample is taken
module rtt_window_mean_jitter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rwmj_pkg::SAMPLE_W-1:0] s_rtt_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rwmj_pkg::RESULT_W-1:0] m_mean_rtt,
    output logic [rwmj_pkg::RESULT_W-1:0] m_jitter,
    output logic [rwmj_pkg::SAMPLE_W-1:0] m_last_rtt,
    output logic [rwmj_pkg::CNT_W-1:0]    m_sample_count
);
    import rwmj_pkg::*;

    rwmj_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [SAMPLE_W-1:0] last_reg, last_next;
    logic [SAMPLE_W-1:0] oldest_reg, oldest_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    sample_sum_reg, sample_sum_next;
    logic [SUM_W-1:0]    diff_sum_reg, diff_sum_next;

    logic                m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0] mean_out_reg, mean_out_next;
    logic [RESULT_W-1:0] jit_out_reg, jit_out_next;
    logic [SAMPLE_W-1:0] last_out_reg, last_out_next;
    logic [CNT_W-1:0]    count_out_reg, count_out_next;

    logic [SLOT_W-1:0]   slot_inc;
    logic                in_xfer;
    logic                out_free;
    logic                window_full;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_addr;
    logic [SAMPLE_W-1:0] mem_rdata;
    logic                div_start;
    logic                load_out;
    logic [DVD_W-1:0]    mean_quo;
    logic [DVD_W-1:0]    jit_quo;
    div_stat_t           mean_stat;
    div_stat_t           jit_stat;
    logic [SAMPLE_W-1:0] evict_diff;
    logic [SAMPLE_W-1:0] new_diff;

    function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign slot_inc    = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + SLOT_W'(1);
    assign in_xfer     = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign window_full = count_reg == CNT_W'(WINDOW_DEPTH);
    assign evict_diff  = abs_diff(oldest_reg, mem_rdata);
    assign new_diff    = abs_diff(sample_reg, last_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = window_full ? ST_RD_OLD : ST_UPDATE;
                end
            end
            ST_RD_OLD:  state_next = ST_RD_NEXT;
            ST_RD_NEXT: state_next = ST_EVICT;
            ST_EVICT:   state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_START;
            ST_START:   state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (mean_stat.done && jit_stat.done && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = slot_reg;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_RD_OLD:  mem_addr = slot_reg;
            ST_RD_NEXT: mem_addr = slot_inc;
            ST_EVICT:   mem_addr = slot_reg;
            ST_UPDATE:  mem_we = 1'b1;
            ST_START:   div_start = 1'b1;
            ST_DIVIDE:  load_out = mean_stat.done && jit_stat.done && out_free;
            default:    s_ready = 1'b0;
        endcase
    end

    // window bookkeeping
    always_comb begin
        sample_next     = sample_reg;
        last_next       = last_reg;
        oldest_next     = oldest_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        sample_sum_next = sample_sum_reg;
        diff_sum_next   = diff_sum_reg;
        if (in_xfer) begin
            sample_next = s_rtt_sample;
        end
        case (state_reg)
            ST_RD_NEXT: oldest_next = mem_rdata;
            ST_EVICT: begin
                // oldest leaves, along with its step to the second oldest
                sample_sum_next = sample_sum_reg - SUM_W'(oldest_reg);
                diff_sum_next   = diff_sum_reg - SUM_W'(evict_diff);
                count_next      = CNT_W'(WINDOW_DEPTH - 1);
            end
            ST_UPDATE: begin
                sample_sum_next = sample_sum_reg + SUM_W'(sample_reg);
                if (count_reg != '0) begin
                    diff_sum_next = diff_sum_reg + SUM_W'(new_diff);
                end
                count_next = count_reg + CNT_W'(1);
                slot_next  = slot_inc;
                last_next  = sample_reg;
            end
            default: count_next = count_reg;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        mean_out_next  = mean_out_reg;
        jit_out_next   = jit_out_reg;
        last_out_next  = last_out_reg;
        count_out_next = count_out_reg;
        if (load_out) begin
            m_valid_next   = 1'b1;
            mean_out_next  = mean_quo[RESULT_W-1:0];
            // no consecutive pair yet with a single sample
            jit_out_next   = (count_reg >= CNT_W'(2)) ? jit_quo[RESULT_W-1:0] : '0;
            last_out_next  = last_reg;
            count_out_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            slot_reg       <= '0;
            count_reg      <= '0;
            sample_sum_reg <= '0;
            diff_sum_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            sample_sum_reg <= sample_sum_next;
            diff_sum_reg   <= diff_sum_next;
            m_valid_reg    <= m_valid_next;
        end
        sample_reg    <= sample_next;
        last_reg      <= last_next;
        oldest_reg    <= oldest_next;
        mean_out_reg  <= mean_out_next;
        jit_out_reg   <= jit_out_next;
        last_out_reg  <= last_out_next;
        count_out_reg <= count_out_next;
    end

    rwmj_ring_mem u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .addr    (mem_addr),
        .wr_data (sample_reg),
        .rd_data (mem_rdata)
    );

    rwmj_serial_div u_mean_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({sample_sum_reg, FRAC_W'(0)}),
        .divisor  (count_reg),
        .quotient (mean_quo),
        .stat     (mean_stat)
    );

    rwmj_serial_div u_jit_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({diff_sum_reg, FRAC_W'(0)}),
        .divisor  (count_reg - CNT_W'(1)),
        .quotient (jit_quo),
        .stat     (jit_stat)
    );

    assign m_valid        = m_valid_reg;
    assign m_mean_rtt     = mean_out_reg;
    assign m_jitter       = jit_out_reg;
    assign m_last_rtt     = last_out_reg;
    assign m_sample_count = count_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("held sample count beyond window depth");

    a_evict_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_OLD) |-> window_full)
        else $error("eviction started on a window that is not full");

    a_divs_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (mean_stat.done == jit_stat.done) && (mean_stat.busy == jit_stat.busy))
        else $error("mean and jitter dividers out of step");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_count != '0))
        else $error("result with an empty window");

    a_single_jitter: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_sample_count == CNT_W'(1))) |-> (m_jitter == '0))
        else $error("jitter reported with a single sample");

endmodule

>>> rtl/rwmj_ring_mem.sv
// rwmj_ring_mem: single-port sample ring, one access per cycle, registered read
// depends on rwmj_pkg
module rwmj_ring_mem (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [rwmj_pkg::SLOT_W-1:0]   addr,
    input  logic [rwmj_pkg::SAMPLE_W-1:0] wr_data,
    output logic [rwmj_pkg::SAMPLE_W-1:0] rd_data
);
    import rwmj_pkg::*;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[addr] <= wr_data;
        end
        rd_data_reg <= ring_mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rwmj_serial_div.sv
// rwmj_serial_div: restoring divider, one quotient bit per cycle through a
// shift register; depends on rwmj_pkg
module rwmj_serial_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [rwmj_pkg::DVD_W-1:0] dividend,
    input  logic [rwmj_pkg::CNT_W-1:0] divisor,
    output logic [rwmj_pkg::DVD_W-1:0] quotient,
    output rwmj_pkg::div_stat_t        stat
);
    import rwmj_pkg::*;

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              fits;

    // shift the next dividend bit into the partial remainder
    assign trial     = {rem_reg, quo_reg[DVD_W-1]};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
